FILE: hdl/ctem_pkg.sv
// Package for the elliptic cluster-to-track matcher.
// Holds the register map, state and command types; imported by every module.
// No dependencies.
`timescale 1ns / 1ps

package ctem_pkg;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Elliptic distance is kept modulo 2^ELL_W
    localparam int ELL_W = 22;

    localparam int WEIGHT_W = 8;
    localparam int PTMIN_W  = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 8'd87;
    localparam logic [ELL_W-1:0]    RADIUS_RST = 22'd256;
    localparam logic [PTMIN_W-1:0]  PTMIN_RST  = 16'd40;

    typedef enum logic [1:0] {
        REG_ETA_WEIGHT = 2'd0,
        REG_RADIUS     = 2'd1,
        REG_PT_MIN     = 2'd2
    } ctem_reg_e;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_MATCH = 1'b1
    } ctem_op_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ctem_state_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [ELL_W-1:0]    radius;
        logic [PTMIN_W-1:0]  pt_min;
    } ctem_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // write the input track into its slot
        logic start;    // latch the cluster and clear the best match
        logic issue;    // send one stored track down the pipeline
        logic capture;  // move the best match into the output register
    } ctem_cmd_t;

endpackage

FILE: hdl/ctem_if.sv
// Valid/ready channel interfaces for the matcher's input and result streams.
// Coordinate and pt widths follow COORD_BITS and PT_BITS; no package dependency.
`timescale 1ns / 1ps

interface ctem_in_if #(
    parameter int COORD_BITS = 10,
    parameter int PT_BITS    = 16
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [3:0]                   track_slot;
    logic signed [COORD_BITS-1:0] obj_eta;
    logic signed [COORD_BITS-1:0] obj_phi;
    logic [PT_BITS-1:0]           obj_pt;
    logic signed [COORD_BITS-1:0] obj_z0;

    modport source (
        output valid, operation, track_slot, obj_eta, obj_phi, obj_pt, obj_z0,
        input  ready
    );
    modport sink (
        input  valid, operation, track_slot, obj_eta, obj_phi, obj_pt, obj_z0,
        output ready
    );
endinterface

interface ctem_out_if #(
    parameter int COORD_BITS = 10,
    parameter int PT_BITS    = 16
);
    logic                         valid;
    logic                         ready;
    logic                         matched;
    logic [3:0]                   track_index;
    logic [PT_BITS-1:0]           pt_difference;
    logic signed [COORD_BITS-1:0] track_z0;

    modport source (
        output valid, matched, track_index, pt_difference, track_z0,
        input  ready
    );
    modport sink (
        input  valid, matched, track_index, pt_difference, track_z0,
        output ready
    );
endinterface

FILE: hdl/ctem_regs.sv
// APB-style configuration registers: eta weight, ellipse radius, track pt minimum.
// Depends on ctem_pkg.
`timescale 1ns / 1ps

module ctem_regs
    import ctem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ctem_cfg_t         cfg
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic [ELL_W-1:0]    radius_reg;
    logic [PTMIN_W-1:0]  pt_min_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RST;
            radius_reg <= RADIUS_RST;
            pt_min_reg <= PTMIN_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_ETA_WEIGHT: weight_reg <= pwdata[WEIGHT_W-1:0];
                REG_RADIUS:     radius_reg <= pwdata[ELL_W-1:0];
                REG_PT_MIN:     pt_min_reg <= pwdata[PTMIN_W-1:0];
                default:        ;  // unmapped address, drop the write
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ETA_WEIGHT: prdata = DATA_W'(weight_reg);
            REG_RADIUS:     prdata = DATA_W'(radius_reg);
            REG_PT_MIN:     prdata = DATA_W'(pt_min_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.weight = weight_reg;
    assign cfg.radius = radius_reg;
    assign cfg.pt_min = pt_min_reg;

endmodule

FILE: hdl/ctem_ctrl.sv
// Controller for the matcher: accepts transactions, sequences the track scan,
// waits for the pipeline to drain and owns the result valid flag. Depends on ctem_pkg.
`timescale 1ns / 1ps

module ctem_ctrl
    import ctem_pkg::*;
#(
    parameter int TRACKS = 16,
    parameter int IW     = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_operation,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  logic          pipe_busy,
    output ctem_cmd_t     cmd,
    output logic [IW-1:0] scan_idx
);

    localparam logic [IW-1:0] LAST_IDX = IW'(TRACKS - 1);

    ctem_state_t   state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        in_ready    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                idx_next = '0;
                if (in_valid)
                begin
                    if (in_operation == OP_MATCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign scan_idx  = idx_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/ctem_datapath.sv
// Datapath for the matcher: track store, cluster latch, four-stage distance
// pipeline, best-match tracker and result register. Depends on ctem_pkg.
`timescale 1ns / 1ps

module ctem_datapath
    import ctem_pkg::*;
#(
    parameter int TRACKS     = 16,
    parameter int COORD_BITS = 10,
    parameter int PT_BITS    = 16,
    parameter int IW         = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctem_cmd_t                    cmd,
    input  logic [IW-1:0]                scan_idx,
    input  ctem_cfg_t                    cfg,
    input  logic [3:0]                   in_slot,
    input  logic signed [COORD_BITS-1:0] in_eta,
    input  logic signed [COORD_BITS-1:0] in_phi,
    input  logic [PT_BITS-1:0]           in_pt,
    input  logic signed [COORD_BITS-1:0] in_z0,
    output logic                         pipe_busy,
    output logic                         res_matched,
    output logic [3:0]                   res_index,
    output logic [PT_BITS-1:0]           res_pt_diff,
    output logic signed [COORD_BITS-1:0] res_z0
);

    // At most sixteen slots are loadable; scan positions above them read as empty
    localparam int SLOTS = (TRACKS < 16) ? TRACKS : 16;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW    = COORD_BITS + 1;
    localparam int SQ    = 2 * DW;
    localparam int PRODW = SQ + WEIGHT_W;
    localparam int SUMW  = PRODW + 1;
    localparam int PMW   = (PT_BITS > PTMIN_W) ? PT_BITS : PTMIN_W;
    localparam logic [PT_BITS-1:0] NO_MATCH = '1;

    // Track store
    logic signed [COORD_BITS-1:0] st_eta_reg [SLOTS];
    logic signed [COORD_BITS-1:0] st_phi_reg [SLOTS];
    logic [PT_BITS-1:0]           st_pt_reg  [SLOTS];
    logic signed [COORD_BITS-1:0] st_z0_reg  [SLOTS];

    logic                         wr_ok;
    logic [SW-1:0]                wr_idx;

    assign wr_ok  = ({1'b0, in_slot} < 5'(SLOTS));
    assign wr_idx = in_slot[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                st_eta_reg[i] <= '0;
                st_phi_reg[i] <= '0;
                st_pt_reg[i]  <= '0;
                st_z0_reg[i]  <= '0;
            end
        end
        else if (cmd.load && wr_ok)
        begin
            st_eta_reg[wr_idx] <= in_eta;
            st_phi_reg[wr_idx] <= in_phi;
            st_pt_reg[wr_idx]  <= in_pt;
            st_z0_reg[wr_idx]  <= in_z0;
        end
    end

    // Cluster latch
    logic signed [COORD_BITS-1:0] clu_eta_reg;
    logic signed [COORD_BITS-1:0] clu_phi_reg;
    logic [PT_BITS-1:0]           clu_pt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            clu_eta_reg <= in_eta;
            clu_phi_reg <= in_phi;
            clu_pt_reg  <= in_pt;
        end
    end

    // Stage A: read one track, differences and pt qualification
    logic                         in_range;
    logic [SW-1:0]                rd_idx;
    logic signed [COORD_BITS-1:0] rd_eta, rd_phi, rd_z0;
    logic [PT_BITS-1:0]           rd_pt;

    assign in_range = ((IW+1)'(scan_idx) < (IW+1)'(SLOTS));
    assign rd_idx   = scan_idx[SW-1:0];
    assign rd_eta   = in_range ? st_eta_reg[rd_idx] : '0;
    assign rd_phi   = in_range ? st_phi_reg[rd_idx] : '0;
    assign rd_pt    = in_range ? st_pt_reg[rd_idx]  : '0;
    assign rd_z0    = in_range ? st_z0_reg[rd_idx]  : '0;

    logic                         a_vld_reg;
    logic [IW-1:0]                a_idx_reg;
    logic signed [COORD_BITS-1:0] a_z0_reg;
    logic signed [DW-1:0]         a_deta_reg, a_dphi_reg;
    logic [PT_BITS-1:0]           a_ptd_reg;
    logic                         a_qual_reg;

    always_ff @(posedge clk)
    begin
        a_idx_reg  <= scan_idx;
        a_z0_reg   <= rd_z0;
        a_deta_reg <= DW'(clu_eta_reg) - DW'(rd_eta);
        a_dphi_reg <= DW'(clu_phi_reg) - DW'(rd_phi);
        a_ptd_reg  <= (clu_pt_reg >= rd_pt) ? clu_pt_reg - rd_pt : rd_pt - clu_pt_reg;
        a_qual_reg <= (PMW'(rd_pt) >= PMW'(cfg.pt_min)) && (clu_pt_reg != '0);
    end

    // Stage B: squares
    logic signed [SQ-1:0]         de2_s, dp2_s;
    logic                         b_vld_reg;
    logic [IW-1:0]                b_idx_reg;
    logic signed [COORD_BITS-1:0] b_z0_reg;
    logic [SQ-1:0]                b_de2_reg, b_dp2_reg;
    logic [PT_BITS-1:0]           b_ptd_reg;
    logic                         b_qual_reg;

    assign de2_s = a_deta_reg * a_deta_reg;
    assign dp2_s = a_dphi_reg * a_dphi_reg;

    always_ff @(posedge clk)
    begin
        b_idx_reg  <= a_idx_reg;
        b_z0_reg   <= a_z0_reg;
        b_de2_reg  <= $unsigned(de2_s);
        b_dp2_reg  <= $unsigned(dp2_s);
        b_ptd_reg  <= a_ptd_reg;
        b_qual_reg <= a_qual_reg;
    end

    // Stage C: eta weighting
    logic                         c_vld_reg;
    logic [IW-1:0]                c_idx_reg;
    logic signed [COORD_BITS-1:0] c_z0_reg;
    logic [PRODW-1:0]             c_prod_reg;
    logic [SQ-1:0]                c_dp2_reg;
    logic [PT_BITS-1:0]           c_ptd_reg;
    logic                         c_qual_reg;

    always_ff @(posedge clk)
    begin
        c_idx_reg  <= b_idx_reg;
        c_z0_reg   <= b_z0_reg;
        c_prod_reg <= PRODW'(b_de2_reg) * PRODW'(cfg.weight);
        c_dp2_reg  <= b_dp2_reg;
        c_ptd_reg  <= b_ptd_reg;
        c_qual_reg <= b_qual_reg;
    end

    // Stage D: elliptic distance, radius test, candidate value
    logic [SUMW-1:0]              ell_sum;
    logic [ELL_W-1:0]             ell;
    logic                         d_vld_reg;
    logic [IW-1:0]                d_idx_reg;
    logic signed [COORD_BITS-1:0] d_z0_reg;
    logic [PT_BITS-1:0]           d_val_reg;

    assign ell_sum = SUMW'(c_dp2_reg) + SUMW'(c_prod_reg >> 2);
    assign ell     = ell_sum[ELL_W-1:0];

    always_ff @(posedge clk)
    begin
        d_idx_reg <= c_idx_reg;
        d_z0_reg  <= c_z0_reg;
        d_val_reg <= (c_qual_reg && (ell <= cfg.radius)) ? c_ptd_reg : NO_MATCH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= cmd.issue;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    assign pipe_busy = a_vld_reg || b_vld_reg || c_vld_reg || d_vld_reg;

    // Best match: strict compare keeps the lowest slot on ties
    logic [PT_BITS-1:0]           best_val_reg;
    logic [IW-1:0]                best_idx_reg;
    logic signed [COORD_BITS-1:0] best_z0_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            best_val_reg <= NO_MATCH;
            best_idx_reg <= '0;
            best_z0_reg  <= '0;
        end
        else if (d_vld_reg && (d_val_reg < best_val_reg))
        begin
            best_val_reg <= d_val_reg;
            best_idx_reg <= d_idx_reg;
            best_z0_reg  <= d_z0_reg;
        end
    end

    // Result register
    logic                         res_matched_reg;
    logic [3:0]                   res_index_reg;
    logic [PT_BITS-1:0]           res_pt_diff_reg;
    logic signed [COORD_BITS-1:0] res_z0_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_matched_reg <= (best_val_reg != NO_MATCH);
            res_index_reg   <= 4'(best_idx_reg);
            res_pt_diff_reg <= best_val_reg;
            res_z0_reg      <= best_z0_reg;
        end
    end

    assign res_matched = res_matched_reg;
    assign res_index   = res_index_reg;
    assign res_pt_diff = res_pt_diff_reg;
    assign res_z0      = res_z0_reg;

endmodule

FILE: hdl/calo_track_elliptic_match.sv
// Elliptic cluster-to-track matcher, top level.
// Depends on ctem_pkg, ctem_if, ctem_regs, ctem_ctrl and ctem_datapath.
//
// Usage:
//   in_ch carries one transaction per item. operation = load writes the track
//   (eta, phi, pt, z0) into track_slot and gives no result; slots at or beyond
//   TRACKS are ignored. operation = match scans every stored track for the
//   cluster in obj_eta/obj_phi/obj_pt and gives one result on res_ch.
//   A load leaves the controller idle, so loads go back to back.
//   A match examines one stored track per cycle through a four-stage distance
//   pipeline (difference, square, eta weighting, radius test); the controller
//   then waits for the pipeline to drain, captures the result into the output
//   register and only then returns to idle to take the next item.
//   The result sits in an output register; loads are still accepted while it
//   waits. If the receiver stalls, a finished match holds in the controller
//   until the output register is free, and in_ch stays not ready meanwhile.
//   Configuration must be written over the APB-style port while the block is idle
//   (the block does not enforce this): eta weight at 0x0, ellipse radius at 0x4, track pt minimum at 0x8.
//   Reset clears the track store to zero, restores register defaults and
//   empties the pipeline and output register.
`timescale 1ns / 1ps

module calo_track_elliptic_match
    import ctem_pkg::*;
#(
    parameter int TRACKS     = 16,
    parameter int COORD_BITS = 10,
    parameter int PT_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    ctem_in_if.sink           in_ch,
    ctem_out_if.source        res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    ctem_cfg_t     cfg;
    ctem_cmd_t     cmd;
    logic [IW-1:0] scan_idx;
    logic          pipe_busy;

    ctem_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctem_ctrl #(
        .TRACKS (TRACKS),
        .IW     (IW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_operation (in_ch.operation),
        .in_ready     (in_ch.ready),
        .out_valid    (res_ch.valid),
        .out_ready    (res_ch.ready),
        .pipe_busy    (pipe_busy),
        .cmd          (cmd),
        .scan_idx     (scan_idx)
    );

    ctem_datapath #(
        .TRACKS     (TRACKS),
        .COORD_BITS (COORD_BITS),
        .PT_BITS    (PT_BITS),
        .IW         (IW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .scan_idx    (scan_idx),
        .cfg         (cfg),
        .in_slot     (in_ch.track_slot),
        .in_eta      (in_ch.obj_eta),
        .in_phi      (in_ch.obj_phi),
        .in_pt       (in_ch.obj_pt),
        .in_z0       (in_ch.obj_z0),
        .pipe_busy   (pipe_busy),
        .res_matched (res_ch.matched),
        .res_index   (res_ch.track_index),
        .res_pt_diff (res_ch.pt_difference),
        .res_z0      (res_ch.track_z0)
    );

endmodule

FILE: hdl/ctem_checker.sv
// Port-level checks for the matcher, attached to the top level by bind.
// Depends on ctem_pkg and calo_track_elliptic_match.
`timescale 1ns / 1ps

module ctem_checker
    import ctem_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int PT_BITS    = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  in_operation,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  matched,
    input logic [3:0]            track_index,
    input logic [PT_BITS-1:0]    pt_difference,
    input logic [COORD_BITS-1:0] track_z0
);

    localparam logic [PT_BITS-1:0] NO_MATCH = '1;

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A match transaction occupies the block for its scan
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_MATCH) |=> !in_ready)
        else $error("input ready straight after a match transaction");

    // A load never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_LOAD) && !out_valid |=> !out_valid)
        else $error("result appeared after a load transaction");

    // No match reports the no-match value with slot and z0 zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |->
            (pt_difference == NO_MATCH) && (track_index == 4'd0) && (track_z0 == '0))
        else $error("inconsistent no-match result");

    // A match reports a value below the no-match value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> (pt_difference != NO_MATCH))
        else $error("match reported with the no-match value");

endmodule

bind calo_track_elliptic_match ctem_checker #(
    .COORD_BITS (COORD_BITS),
    .PT_BITS    (PT_BITS)
) u_ctem_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_operation  (in_ch.operation),
    .out_valid     (res_ch.valid),
    .out_ready     (res_ch.ready),
    .matched       (res_ch.matched),
    .track_index   (res_ch.track_index),
    .pt_difference (res_ch.pt_difference),
    .track_z0      (res_ch.track_z0)
);
